// ===== rtl/rcio_pkg.sv =====
// ----------------------------------------------------------------------------
// rcio_pkg: shared types and constants for the cabinet input block
// Item layout, kind and page codes, per-player status and reset values.
// ----------------------------------------------------------------------------
package rcio_pkg;

   localparam int RCIO_PLAYERS = 4;   // default number of fitted players
   localparam int SLOTS        = 4;   // player slots decoded on the bus

   localparam logic [7:0] DIP_RESET  = 8'd191;
   localparam logic [3:0] LATCH_MASK = 4'd15;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_WRITE   = 2'd1,
      KIND_SAMPLE  = 2'd2,
      KIND_COLLIDE = 2'd3
   } kind_type;

   // address bits 6..5 select the page of the I/O map
   typedef enum logic [1:0] {
      PAGE_ANALOG = 2'd0,
      PAGE_COIN   = 2'd1,
      PAGE_GAS    = 2'd2,
      PAGE_DIP    = 2'd3
   } page_type;

   typedef struct packed {
      kind_type    kind;
      logic [6:0]  address;
      logic [7:0]  write_data;
      logic [1:0]  player;
      logic [7:0]  wheel_position;
      logic [3:0]  gear_buttons;
      logic [7:0]  coin_switches;
      logic [3:0]  gas_buttons;
   } item_type;

   typedef struct packed {
      logic        step;
      logic        direction;
      logic [2:0]  gear;
      logic        collision;
   } player_status_type;

endpackage

// ===== rtl/racing_cabinet_input_io_core.sv =====
// ----------------------------------------------------------------------------
// racing_cabinet_input_io_core: four-player driving cabinet input block
// Bus reads and writes of the I/O page, wheel/gear samples, collisions.
// ----------------------------------------------------------------------------
//  channel | ports              | handshake
//  --------+--------------------+--------------------------------
//  request | req_*              | req_valid / req_ready
//  result  | rsp_*              | rsp_valid / rsp_ready
//  config  | csr_write_*        | csr_write_enable, no wait
//
//  One beat per cycle sustained while rsp_ready stays high; a beat passes
//  the input register, then the result register, before it shows on rsp.
//  State updates and the result are formed in the cycle the beat
//  leaves the input register, so beats see state in arrival order.
//  Synchronous reset clears the valid flags and all player, latch and lamp
//  state; option switches reset to 191. A stalled result stage holds the
//  input register; req_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module racing_cabinet_input_io_core
   import rcio_pkg::*;
#(
   parameter int PLAYERS = RCIO_PLAYERS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [6:0] req_address,
   input  logic [7:0] req_write_data,
   input  logic [1:0] req_player,
   input  logic [7:0] req_wheel_position,
   input  logic [3:0] req_gear_buttons,
   input  logic [7:0] req_coin_switches,
   input  logic [3:0] req_gas_buttons,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic [3:0] rsp_lamp_states,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   item_type   req_item;
   item_type   stage_ff;
   logic       stage_valid_ff, stage_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff;
   logic [3:0] rsp_lamp_states_ff;
   logic       advance;
   logic       accept;

   player_status_type [SLOTS-1:0] status;
   logic [7:0]                    read_data;
   logic [3:0]                    lamps_next;

   assign req_item.kind           = kind_type'(req_kind);
   assign req_item.address        = req_address;
   assign req_item.write_data     = req_write_data;
   assign req_item.player         = req_player;
   assign req_item.wheel_position = req_wheel_position;
   assign req_item.gear_buttons   = req_gear_buttons;
   assign req_item.coin_switches  = req_coin_switches;
   assign req_item.gas_buttons    = req_gas_buttons;

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign stage_valid_in = accept || (stage_valid_ff && !advance);
   assign rsp_valid_in   = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= req_item;
      end
      if (advance) begin
         rsp_read_data_ff   <= read_data;
         rsp_lamp_states_ff <= lamps_next;
      end
   end

   rcio_player_bank #(
      .PLAYERS(PLAYERS)
   ) u_player_bank (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (stage_ff),
      .status  (status)
   );

   rcio_bus_port u_bus_port (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item             (stage_ff),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .read_data        (read_data),
      .lamps_next       (lamps_next)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_lamp_states = rsp_lamp_states_ff;

endmodule

// ===== rtl/rcio_player_bank.sv =====
// ----------------------------------------------------------------------------
// rcio_player_bank: per-player wheel, gear and collision state
// One lane per fitted player; unfitted slots read as reset values.
// ----------------------------------------------------------------------------
module rcio_player_bank
   import rcio_pkg::*;
#(
   parameter int PLAYERS = RCIO_PLAYERS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  item_type                            item,
   output player_status_type [SLOTS-1:0]       status
);

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      if (i < PLAYERS) begin : g_lane
         logic [7:0] last_wheel_ff, last_wheel_in;
         logic       direction_ff, direction_in;
         logic       step_ff, step_in;
         logic [2:0] gear_ff, gear_in;
         logic       collision_ff, collision_in;
         logic [7:0] delta;
         logic       hit;
         logic       sample_en;
         logic       collide_en;
         logic       clear_en;

         assign hit        = (item.player == 2'(i));
         assign sample_en  = advance && (item.kind == KIND_SAMPLE) && hit;
         assign collide_en = advance && (item.kind == KIND_COLLIDE) && hit;
         // any write into the coin page clears the addressed flag
         assign clear_en   = advance && (item.kind == KIND_WRITE)
                             && (page_type'(item.address[6:5]) == PAGE_COIN)
                             && (item.address[2:1] == 2'(i));
         assign delta      = item.wheel_position - last_wheel_ff;

         always_comb begin
            last_wheel_in = last_wheel_ff;
            direction_in  = direction_ff;
            step_in       = step_ff;
            gear_in       = gear_ff;
            collision_in  = collision_ff;
            if (sample_en) begin
               last_wheel_in = item.wheel_position;
               step_in       = last_wheel_ff[0];
               // equal count keeps the direction
               if (delta[7]) begin
                  direction_in = 1'b0;
               end else if (delta != 8'd0) begin
                  direction_in = 1'b1;
               end
               unique case (item.gear_buttons)
                  4'b0001: gear_in = 3'd1;
                  4'b0010: gear_in = 3'd2;
                  4'b0100: gear_in = 3'd3;
                  4'b1000: gear_in = 3'd4;
                  default: gear_in = gear_ff;
               endcase
            end
            if (collide_en) begin
               collision_in = 1'b1;
            end else if (clear_en) begin
               collision_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               last_wheel_ff <= '0;
               direction_ff  <= 1'b0;
               step_ff       <= 1'b0;
               gear_ff       <= '0;
               collision_ff  <= 1'b0;
            end else begin
               last_wheel_ff <= last_wheel_in;
               direction_ff  <= direction_in;
               step_ff       <= step_in;
               gear_ff       <= gear_in;
               collision_ff  <= collision_in;
            end
         end

         assign status[i].step      = step_ff;
         assign status[i].direction = direction_ff;
         assign status[i].gear      = gear_ff;
         assign status[i].collision = collision_ff;
      end else begin : g_empty
         assign status[i] = '0;
      end
   end

endmodule

// ===== rtl/rcio_bus_port.sv =====
// ----------------------------------------------------------------------------
// rcio_bus_port: I/O page read mux and write registers
// Holds the comparator latch, start lamps and option switch byte.
// ----------------------------------------------------------------------------
module rcio_bus_port
   import rcio_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  item_type                      item,
   input  player_status_type [SLOTS-1:0] status,
   input  logic                          csr_write_enable,
   input  logic [7:0]                    csr_write_data,
   output logic [7:0]                    read_data,
   output logic [3:0]                    lamps_next
);

   logic [3:0] latch_ff, latch_in;
   logic [3:0] lamps_ff, lamps_in;
   logic [7:0] dip_ff;

   logic [1:0]        slot;
   player_status_type sel_status;
   logic [4:0]        volts;
   logic [7:0]        gas_port;
   logic [7:0]        page_data;
   logic              is_write;

   assign slot       = item.address[2:1];
   assign sel_status = status[slot];
   assign is_write   = advance && (item.kind == KIND_WRITE);

   always_comb begin
      latch_in = latch_ff;
      lamps_in = lamps_ff;
      if (is_write) begin
         if (item.address[6:1] == 6'b100000) begin
            latch_in = item.write_data[3:0] & LATCH_MASK;
         end else if (item.address[6:3] == 4'b1100) begin
            lamps_in[slot] = item.address[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= '0;
         lamps_ff <= '0;
         dip_ff   <= DIP_RESET;
      end else begin
         latch_ff <= latch_in;
         lamps_ff <= lamps_in;
         if (csr_write_enable) begin
            dip_ff <= csr_write_data;
         end
      end
   end

   // gas pedals on even bits, collision flags on odd bits
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         gas_port[2*i]   = item.gas_buttons[i];
         gas_port[2*i+1] = status[i].collision;
      end
   end

   // analog level: 4 per gear, or 8 per set steering bit
   assign volts = item.address[0] ? {sel_status.gear, 2'b00}
                                  : {sel_status.step & sel_status.direction,
                                     sel_status.step ^ sel_status.direction, 3'b000};

   always_comb begin
      unique case (page_type'(item.address[6:5]))
         PAGE_ANALOG: page_data = {(volts > {1'b0, latch_ff}), 7'd0};
         PAGE_COIN:   page_data = {item.coin_switches[item.address[2:0]], 7'd0};
         PAGE_GAS:    page_data = {gas_port[item.address[2:0]], 7'd0};
         PAGE_DIP:    page_data = {6'd0, dip_ff[2*item.address[1:0] +: 2]};
         default:     page_data = '0;
      endcase
   end

   assign read_data  = (item.kind == KIND_READ) ? page_data : 8'd0;
   assign lamps_next = lamps_in;

endmodule

// ===== rtl/rcio_checker.sv =====
// ----------------------------------------------------------------------------
// rcio_checker: port-level checks for the cabinet input block
// Bound onto the top level; watches the request and result channels.
// ----------------------------------------------------------------------------
module rcio_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic [3:0] rsp_lamp_states
);

   // nothing comes out the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                  && $stable(rsp_lamp_states))
      else $error("stalled result beat changed");

   // every read source lands in bit 7 or the low two bits only
   a_data_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_read_data[6:2] == 5'd0)
      else $error("read data has bits outside the map");

   a_data_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data[1:0] != 2'd0) |-> !rsp_read_data[7])
      else $error("switch bits and bit 7 set together");

   // with the result stage empty the input side cannot be blocked
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !$past(req_valid && req_ready) |-> req_ready)
      else $error("request stalled with empty pipeline");

endmodule

bind racing_cabinet_input_io_core rcio_checker u_rcio_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_data   (rsp_read_data),
   .rsp_lamp_states (rsp_lamp_states)
);

// ===== sim/tb_racing_cabinet_input_io_core.sv =====
// ----------------------------------------------------------------------------
// tb_racing_cabinet_input_io_core: self-checking bench for the cabinet input
// Drives bus reads and writes, wheel/gear samples and collision beats through
// the request channel. A local copy of the player state predicts each result,
// and every result beat is checked in order. Idling and stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_racing_cabinet_input_io_core;
   import rcio_pkg::*;

   localparam int NUM_PLAYERS = RCIO_PLAYERS;

   // I/O page windows
   localparam logic [6:0] ADDR_ANALOG   = 7'h00;
   localparam logic [6:0] ADDR_COIN     = 7'h20;
   localparam logic [6:0] ADDR_CLEAR_HI = 7'h3F;
   localparam logic [6:0] ADDR_GAS      = 7'h40;
   localparam logic [6:0] ADDR_LATCH_LO = 7'h40;
   localparam logic [6:0] ADDR_LATCH_HI = 7'h41;
   localparam logic [6:0] ADDR_DIP      = 7'h60;
   localparam logic [6:0] ADDR_LAMP_HI  = 7'h67;

   localparam logic [7:0] READ_HIGH = 8'h80;

   typedef struct packed {
      logic [7:0] read_data;
      logic [3:0] lamp_states;
   } cabinet_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_kind;
   logic [6:0] req_address;
   logic [7:0] req_write_data;
   logic [1:0] req_player;
   logic [7:0] req_wheel_position;
   logic [3:0] req_gear_buttons;
   logic [7:0] req_coin_switches;
   logic [3:0] req_gas_buttons;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_read_data;
   logic [3:0] rsp_lamp_states;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   // predicted cabinet state
   logic [7:0] dial_prev  [4] = '{default: '0};
   logic       dir_bit    [4] = '{default: '0};
   logic       step_bit   [4] = '{default: '0};
   logic [2:0] gear_sel   [4] = '{default: '0};
   logic       crash_flag [4] = '{default: '0};
   logic [3:0] cmp_level   = '0;
   logic [3:0] lamp_bits   = '0;
   logic [7:0] option_byte = DIP_RESET;

   cabinet_result_type predicted_responses[$];

   int send_gap_pct      = 0;
   int rsp_stall_pct     = 0;
   int hold_off_request  = 0;
   int errors            = 0;
   int results_seen      = 0;
   int settings_used     = 1;
   int beats_by_kind [4] = '{default: 0};

   racing_cabinet_input_io_core #(
      .PLAYERS(NUM_PLAYERS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_address        (req_address),
      .req_write_data     (req_write_data),
      .req_player         (req_player),
      .req_wheel_position (req_wheel_position),
      .req_gear_buttons   (req_gear_buttons),
      .req_coin_switches  (req_coin_switches),
      .req_gas_buttons    (req_gas_buttons),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data),
      .rsp_lamp_states    (rsp_lamp_states),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("%0t: timed out with %0d results outstanding", $time,
               predicted_responses.size());
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   task automatic apply_cabinet_beat(input item_type it, output logic [7:0] rd);
      logic [1:0] n;
      logic [2:0] sel;
      logic [7:0] port;
      logic [7:0] delta;
      logic [7:0] shifted;
      int         volts;
      n  = it.address[2:1];
      sel = it.address[2:0];
      rd = '0;
      case (it.kind)
         KIND_READ: begin
            case (page_type'(it.address[6:5]))
               PAGE_ANALOG: begin
                  if (it.address[0])
                     volts = 4 * int'(gear_sel[n]);
                  else
                     volts = 8 * int'(step_bit[n]) + 8 * int'(dir_bit[n]);
                  rd = (volts > int'(cmp_level)) ? READ_HIGH : 8'h00;
               end
               PAGE_COIN: rd = {it.coin_switches[sel], 7'd0};
               PAGE_GAS: begin
                  for (int i = 0; i < 4; i++) begin
                     port[2*i]   = it.gas_buttons[i];
                     port[2*i+1] = crash_flag[i];
                  end
                  rd = {port[sel], 7'd0};
               end
               default: begin
                  shifted = option_byte >> (2 * it.address[1:0]);
                  rd = {6'd0, shifted[1:0]};
               end
            endcase
         end
         KIND_WRITE: begin
            if (it.address >= ADDR_COIN && it.address <= ADDR_CLEAR_HI)
               crash_flag[n] = 1'b0;
            else if (it.address == ADDR_LATCH_LO || it.address == ADDR_LATCH_HI)
               cmp_level = it.write_data[3:0] & LATCH_MASK;
            else if (it.address >= ADDR_DIP && it.address <= ADDR_LAMP_HI)
               lamp_bits[n] = it.address[0];
         end
         KIND_SAMPLE: begin
            if (int'(it.player) < NUM_PLAYERS) begin
               delta = it.wheel_position - dial_prev[it.player];
               if (delta[7])
                  dir_bit[it.player] = 1'b0;
               else if (delta != 8'd0)
                  dir_bit[it.player] = 1'b1;
               step_bit[it.player] = dial_prev[it.player][0];
               case (it.gear_buttons)
                  4'b0001: gear_sel[it.player] = 3'd1;
                  4'b0010: gear_sel[it.player] = 3'd2;
                  4'b0100: gear_sel[it.player] = 3'd3;
                  4'b1000: gear_sel[it.player] = 3'd4;
                  default: ;
               endcase
               dial_prev[it.player] = it.wheel_position;
            end
         end
         default: begin
            if (int'(it.player) < NUM_PLAYERS)
               crash_flag[it.player] = 1'b1;
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   function automatic item_type beat(kind_type k, logic [6:0] a, logic [7:0] d,
                                     logic [1:0] p, logic [7:0] w, logic [3:0] g,
                                     logic [7:0] c, logic [3:0] s);
      item_type it;
      it.kind           = k;
      it.address        = a;
      it.write_data     = d;
      it.player         = p;
      it.wheel_position = w;
      it.gear_buttons   = g;
      it.coin_switches  = c;
      it.gas_buttons    = s;
      return it;
   endfunction

   // Leaves valid high on return so back-to-back beats need no second drive.
   task automatic send_beat(input item_type it);
      cabinet_result_type r;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_kind           <= it.kind;
      req_address        <= it.address;
      req_write_data     <= it.write_data;
      req_player         <= it.player;
      req_wheel_position <= it.wheel_position;
      req_gear_buttons   <= it.gear_buttons;
      req_coin_switches  <= it.coin_switches;
      req_gas_buttons    <= it.gas_buttons;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_cabinet_beat(it, r.read_data);
      r.lamp_states = lamp_bits;
      predicted_responses.push_back(r);
      beats_by_kind[it.kind]++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (predicted_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_option_switches(input logic [7:0] value);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      option_byte = value;
      settings_used++;
   endtask

   // Mostly well-formed traffic: writes aimed at live windows, one-hot gears,
   // small wheel moves so the equal and sign cases come up often.
   function automatic item_type random_beat();
      item_type   it;
      logic [7:0] nudge;
      int         pick;
      it.kind           = kind_type'($urandom_range(3));
      it.address        = 7'($urandom);
      it.write_data     = 8'($urandom);
      it.player         = 2'($urandom);
      it.wheel_position = 8'($urandom);
      it.gear_buttons   = 4'($urandom);
      it.coin_switches  = 8'($urandom);
      it.gas_buttons    = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
         it.kind = KIND_READ;
      end else if (pick < 65) begin
         it.kind = KIND_WRITE;
         case ($urandom_range(9))
            0, 1, 2: it.address = ADDR_COIN + 7'($urandom_range(31));
            3, 4:    it.address = ADDR_LATCH_LO + 7'($urandom_range(1));
            5, 6, 7: it.address = ADDR_DIP + 7'($urandom_range(7));
            default: ;
         endcase
      end else if (pick < 90) begin
         it.kind = KIND_SAMPLE;
         if ($urandom_range(3) != 0)
            it.gear_buttons = 4'b0001 << $urandom_range(3);
         if ($urandom_range(1) == 0) begin
            nudge = 8'($urandom_range(8));
            it.wheel_position = dial_prev[it.player] + nudge - 8'd4;
         end
      end else begin
         it.kind = KIND_COLLIDE;
      end
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      cabinet_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (predicted_responses.size() == 0) begin
            errors++;
            $display("%0t: result beat with nothing expected: read_data %02h lamps %h",
                     $time, rsp_read_data, rsp_lamp_states);
         end else begin
            want = predicted_responses.pop_front();
            if (rsp_read_data !== want.read_data) begin
               errors++;
               $display("%0t: read_data mismatch: expected %02h, got %02h",
                        $time, want.read_data, rsp_read_data);
            end
            if (rsp_lamp_states !== want.lamp_states) begin
               errors++;
               $display("%0t: lamp_states mismatch: expected %h, got %h",
                        $time, want.lamp_states, rsp_lamp_states);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      // option bits and analog input straight out of reset
      send_beat(beat(KIND_READ, ADDR_DIP, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_READ, ADDR_DIP + 7'd3, 8'hFF, 2'd3, 8'hFF, 4'hF, 8'hFF, 4'hF));
      send_beat(beat(KIND_READ, ADDR_ANALOG, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      // wheel: rising, equal (direction kept), half-turn (reads as backwards),
      // wrap through 0xFF; gear held for non one-hot levers
      send_beat(beat(KIND_SAMPLE, 7'h00, 8'h00, 2'd0, 8'h10, 4'b0001, 8'h00, 4'h0));
      send_beat(beat(KIND_SAMPLE, 7'h00, 8'h00, 2'd0, 8'h10, 4'b0000, 8'h00, 4'h0));
      send_beat(beat(KIND_SAMPLE, 7'h00, 8'h00, 2'd0, 8'h90, 4'b1000, 8'h00, 4'h0));
      send_beat(beat(KIND_SAMPLE, 7'h00, 8'h00, 2'd0, 8'hFF, 4'b0011, 8'h00, 4'h0));
      send_beat(beat(KIND_SAMPLE, 7'h7F, 8'hFF, 2'd0, 8'h00, 4'b1111, 8'hFF, 4'hF));
      send_beat(beat(KIND_READ, ADDR_ANALOG, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      // comparator latch at its top, then at zero via the second address
      send_beat(beat(KIND_WRITE, ADDR_LATCH_LO, 8'hFF, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_READ, ADDR_ANALOG + 7'd1, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_SAMPLE, 7'h00, 8'h00, 2'd1, 8'h01, 4'b0100, 8'h00, 4'h0));
      send_beat(beat(KIND_READ, ADDR_ANALOG + 7'd3, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, ADDR_LATCH_HI, 8'hF0, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_READ, ADDR_ANALOG + 7'd3, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      // collision flag is held until its clear write
      send_beat(beat(KIND_COLLIDE, 7'h00, 8'h00, 2'd3, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_READ, ADDR_GAS + 7'd7, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'hF));
      send_beat(beat(KIND_WRITE, ADDR_COIN + 7'd6, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_READ, ADDR_GAS + 7'd7, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'hF));
      send_beat(beat(KIND_READ, ADDR_GAS + 7'd6, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'b1000));
      send_beat(beat(KIND_READ, ADDR_COIN, 8'h00, 2'd0, 8'h00, 4'h0, 8'h01, 4'h0));
      send_beat(beat(KIND_READ, ADDR_COIN + 7'd7, 8'h00, 2'd0, 8'h00, 4'h0, 8'h7F, 4'h0));
      // lamps on and off, then writes that hit nothing
      send_beat(beat(KIND_WRITE, ADDR_DIP + 7'd1, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, ADDR_LAMP_HI, 8'h00, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, ADDR_LAMP_HI - 7'd1, 8'hFF, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, 7'h00, 8'hFF, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, ADDR_LATCH_HI + 7'd1, 8'hFF, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, ADDR_LAMP_HI + 7'd1, 8'hFF, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      send_beat(beat(KIND_WRITE, 7'h7F, 8'hFF, 2'd0, 8'h00, 4'h0, 8'h00, 4'h0));
      wait_for_drain();
   endtask

   task automatic test_option_switches();
      logic [7:0] values [4];
      values = '{8'h00, 8'hFF, 8'hA5, 8'($urandom)};
      foreach (values[v]) begin
         write_option_switches(values[v]);
         for (int i = 0; i < 4; i++)
            send_beat(beat(KIND_READ, ADDR_DIP + 7'(i), 8'($urandom), 2'($urandom),
                           8'($urandom), 4'($urandom), 8'($urandom), 4'($urandom)));
      end
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int count, input int gap_pct,
                                      input int stall_pct);
      write_option_switches(8'($urandom));
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_beat(random_beat());
      wait_for_drain();
   endtask

   // long receiver hold-off while beats keep coming, so req_ready must drop
   task automatic test_backpressure();
      send_gap_pct     = 0;
      rsp_stall_pct    = 0;
      hold_off_request = 60;
      repeat (24) send_beat(random_beat());
      wait_for_drain();
   endtask

   initial begin
      reset              <= 1'b1;
      req_valid          <= 1'b0;
      req_kind           <= KIND_READ;
      req_address        <= '0;
      req_write_data     <= '0;
      req_player         <= '0;
      req_wheel_position <= '0;
      req_gear_buttons   <= '0;
      req_coin_switches  <= '0;
      req_gas_buttons    <= '0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_option_switches();
      test_random_traffic(300, 0, 0);
      test_random_traffic(280, 60, 0);
      test_random_traffic(280, 0, 60);
      test_random_traffic(280, 7, 7);
      test_backpressure();

      wait_for_drain();
      repeat (8) @(posedge clock);
      $display("Ran %0d reads, %0d writes, %0d samples and %0d collisions",
               beats_by_kind[KIND_READ], beats_by_kind[KIND_WRITE],
               beats_by_kind[KIND_SAMPLE], beats_by_kind[KIND_COLLIDE]);
      $display("across %0d option settings; %0d result beats checked, %0d errors",
               settings_used, results_seen, errors);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== racing_cabinet_input_io_core.f =====
rtl/rcio_pkg.sv
rtl/rcio_player_bank.sv
rtl/rcio_bus_port.sv
rtl/racing_cabinet_input_io_core.sv
rtl/rcio_checker.sv
sim/tb_racing_cabinet_input_io_core.sv
